### rtl/core/pstq_pkg.sv
`default_nettype none

package pstq_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ActionW = 3;
  localparam int unsigned TaskW   = 5;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned PosW    = 5;
  localparam int unsigned CountW  = 6;

  // Action codes
  localparam logic [ActionW-1:0] ACT_CLEAR    = 3'd0;
  localparam logic [ActionW-1:0] ACT_ADD      = 3'd1;
  localparam logic [ActionW-1:0] ACT_REMOVE   = 3'd2;
  localparam logic [ActionW-1:0] ACT_CONTAINS = 3'd3;
  localparam logic [ActionW-1:0] ACT_READ     = 3'd4;

  // One list slot as stored in the memory
  typedef struct packed {
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] prio;
  } entry_t;

  // One result item
  typedef struct packed {
    logic              accepted;
    logic              present;
    logic              entry_valid;
    logic [TaskW-1:0]  entry_task;
    logic [PrioW-1:0]  entry_prio;
    logic [CountW-1:0] count;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/pstq_mem.sv
`default_nettype none

module pstq_mem
  import pstq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned IdxW        = $clog2(QUEUE_DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IdxW-1:0] waddr,
  input  wire entry_t          wdata,
  input  wire logic            re,
  input  wire logic [IdxW-1:0] raddr,
  output entry_t               rdata
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/pstq_ctrl.sv
`default_nettype none

module pstq_ctrl
  import pstq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned IdxW        = $clog2(QUEUE_DEPTH),
  parameter int unsigned CntW        = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [ActionW-1:0] in_action,
  input  wire logic [TaskW-1:0]   in_task_id,
  input  wire logic [PrioW-1:0]   in_priority_req,
  input  wire logic [PosW-1:0]    in_position,
  input  wire logic               out_free,
  output logic                    push,
  output result_t                 res,
  output logic                    mem_we,
  output logic [IdxW-1:0]         mem_waddr,
  output entry_t                  mem_wdata,
  output logic                    mem_re,
  output logic [IdxW-1:0]         mem_raddr,
  input  wire entry_t             mem_rdata
);

  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_PUT   = 6'b001000,
    S_FETCH = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Control state
  state_t          state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            iss_on_r, iss_on_nxt;
  logic            rvld_r;

  // Item and working registers
  logic [ActionW-1:0] act_r, act_nxt;
  logic [TaskW-1:0]   id_r, id_nxt;
  logic [PrioW-1:0]   prio_r, prio_nxt;
  logic [IdxW-1:0]    iss_r, iss_nxt;
  logic [IdxW-1:0]    iss_last_r, iss_last_nxt;
  logic               up_r, up_nxt;
  logic [IdxW-1:0]    ridx_r;
  logic               found_r, found_nxt;
  logic [IdxW-1:0]    fidx_r, fidx_nxt;
  logic               ins_set_r, ins_set_nxt;
  logic [IdxW-1:0]    ins_r, ins_nxt;
  result_t            res_r, res_nxt;

  logic            hit, lower, found_now, ins_set_now, at_last;
  logic [IdxW-1:0] fidx_now, ins_now, last_idx;
  logic [CntW-1:0] count_dec;

  assign in_stall  = (state_r != S_IDLE);
  assign count_dec = count_r - CntW'(1);
  assign last_idx  = IdxW'(count_dec);
  assign at_last   = (ridx_r == last_idx);

  // Compare the entry just read against the held item
  assign hit         = rvld_r && (mem_rdata.task_id == id_r);
  assign lower       = rvld_r && (mem_rdata.prio < prio_r);
  assign found_now   = found_r | hit;
  assign fidx_now    = found_r ? fidx_r : ridx_r;
  assign ins_set_now = ins_set_r | lower;
  assign ins_now     = ins_set_r ? ins_r : ridx_r;

  // Result with the final entry count
  always_comb begin
    res       = res_r;
    res.count = CountW'(count_r);
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    act_nxt      = act_r;
    id_nxt       = id_r;
    prio_nxt     = prio_r;
    iss_on_nxt   = iss_on_r;
    iss_nxt      = iss_r;
    iss_last_nxt = iss_last_r;
    up_nxt       = up_r;
    found_nxt    = found_r;
    fidx_nxt     = fidx_r;
    ins_set_nxt  = ins_set_r;
    ins_nxt      = ins_r;
    res_nxt      = res_r;
    push         = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = mem_rdata;

    // Issue one read per cycle and step the read address
    mem_re    = iss_on_r;
    mem_raddr = iss_r;
    if (iss_on_r) begin
      if (iss_r == iss_last_r) begin
        iss_on_nxt = 1'b0;
      end else if (up_r) begin
        iss_nxt = iss_r + IdxW'(1);
      end else begin
        iss_nxt = iss_r - IdxW'(1);
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt  = in_action;
          id_nxt   = in_task_id;
          prio_nxt = in_priority_req;
          res_nxt  = '0;
          unique case (in_action)
            ACT_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            ACT_ADD, ACT_REMOVE, ACT_CONTAINS: begin
              if (in_action == ACT_ADD && count_r == CntW'(QUEUE_DEPTH)) begin
                state_nxt = S_DONE;
              end else if (count_r == '0) begin
                if (in_action == ACT_ADD) begin
                  ins_nxt   = '0;
                  state_nxt = S_PUT;
                end else begin
                  state_nxt = S_DONE;
                end
              end else begin
                // Walk the whole list from the head
                iss_on_nxt   = 1'b1;
                iss_nxt      = '0;
                iss_last_nxt = last_idx;
                up_nxt       = 1'b1;
                found_nxt    = 1'b0;
                ins_set_nxt  = 1'b0;
                state_nxt    = S_SCAN;
              end
            end
            ACT_READ: begin
              if (CmpW'(in_position) < CmpW'(count_r)) begin
                iss_on_nxt   = 1'b1;
                iss_nxt      = IdxW'(CmpW'(in_position));
                iss_last_nxt = IdxW'(CmpW'(in_position));
                state_nxt    = S_FETCH;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rvld_r) begin
          found_nxt   = found_now;
          fidx_nxt    = fidx_now;
          ins_set_nxt = ins_set_now;
          ins_nxt     = ins_now;
          if (at_last) begin
            unique case (act_r)
              ACT_CONTAINS: begin
                res_nxt.present = found_now;
                state_nxt       = S_DONE;
              end
              ACT_ADD: begin
                if (found_now) begin
                  state_nxt = S_DONE;
                end else if (!ins_set_now) begin
                  // Append at the tail
                  ins_nxt   = IdxW'(count_r);
                  state_nxt = S_PUT;
                end else begin
                  // Move the tail down by one, last entry first
                  iss_on_nxt   = 1'b1;
                  iss_nxt      = last_idx;
                  iss_last_nxt = ins_now;
                  up_nxt       = 1'b0;
                  state_nxt    = S_SHIFT;
                end
              end
              ACT_REMOVE: begin
                if (!found_now) begin
                  state_nxt = S_DONE;
                end else if (fidx_now == last_idx) begin
                  count_nxt        = count_dec;
                  res_nxt.accepted = 1'b1;
                  state_nxt        = S_DONE;
                end else begin
                  // Pull the entries after the hit up by one
                  iss_on_nxt   = 1'b1;
                  iss_nxt      = fidx_now + IdxW'(1);
                  iss_last_nxt = last_idx;
                  up_nxt       = 1'b1;
                  state_nxt    = S_SHIFT;
                end
              end
              default: begin
                state_nxt = S_DONE;
              end
            endcase
          end
        end
      end

      S_SHIFT: begin
        if (rvld_r) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          mem_waddr = up_r ? (ridx_r - IdxW'(1)) : (ridx_r + IdxW'(1));
          if (up_r && at_last) begin
            count_nxt        = count_dec;
            res_nxt.accepted = 1'b1;
            state_nxt        = S_DONE;
          end else if (!up_r && ridx_r == ins_r) begin
            state_nxt = S_PUT;
          end
        end
      end

      S_PUT: begin
        mem_we            = 1'b1;
        mem_waddr         = ins_r;
        mem_wdata.task_id = id_r;
        mem_wdata.prio    = prio_r;
        count_nxt         = count_r + CntW'(1);
        res_nxt.accepted  = 1'b1;
        state_nxt         = S_DONE;
      end

      S_FETCH: begin
        if (rvld_r) begin
          res_nxt.entry_valid = 1'b1;
          res_nxt.entry_task  = mem_rdata.task_id;
          res_nxt.entry_prio  = mem_rdata.prio;
          state_nxt           = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      iss_on_r <= 1'b0;
      rvld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      iss_on_r <= iss_on_nxt;
      rvld_r   <= iss_on_r;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    id_r       <= id_nxt;
    prio_r     <= prio_nxt;
    iss_r      <= iss_nxt;
    iss_last_r <= iss_last_nxt;
    up_r       <= up_nxt;
    ridx_r     <= iss_r;
    found_r    <= found_nxt;
    fidx_r     <= fidx_nxt;
    ins_set_r  <= ins_set_nxt;
    ins_r      <= ins_nxt;
    res_r      <= res_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/priority_sorted_task_queue_unit.sv
// Sorted task list of up to QUEUE_DEPTH ids held in one single-port-write,
// registered-read memory, highest priority at position 0 and equal
// priorities in arrival order. One item is worked on at a time; the memory
// read port, one entry per cycle, sets the pace. With N entries, clear,
// unknown actions, a read past the end, an add to a full list and a remove
// or contains on an empty list go straight to the done state; an add to an
// empty list writes slot 0, and a read inside the list fetches one entry.
// Contains, a duplicate add, a remove of an absent id and a remove of the
// last entry walk the whole list. An add that lands at the tail walks the
// list and then writes there. An add that inserts at position P below N
// walks the list and then moves N - P entries down. A remove of the entry
// at P below N - 1 walks the list and then pulls the entries after it up.
// The result waits in the done state while the output register still holds
// an untaken result. Because the result sits in that output register, the
// next item is taken while a result waits to be drained.
`default_nettype none

module priority_sorted_task_queue_unit
  import pstq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [ActionW-1:0] in_action,
  input  wire logic [TaskW-1:0]   in_task_id,
  input  wire logic [PrioW-1:0]   in_priority_req,
  input  wire logic [PosW-1:0]    in_position,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_accepted,
  output logic                    out_present,
  output logic                    out_entry_valid,
  output logic [TaskW-1:0]        out_entry_task,
  output logic [PrioW-1:0]        out_entry_prio,
  output logic [CountW-1:0]       out_count
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic            out_valid_r;
  result_t         out_r;
  logic            out_free;
  logic            push;
  result_t         res;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  entry_t          mem_rdata;

  assign out_free = !out_valid_r || !out_stall;

  pstq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IdxW        (IdxW),
    .CntW        (CntW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .in_position     (in_position),
    .out_free        (out_free),
    .push            (push),
    .res             (res),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  pstq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IdxW        (IdxW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Hold the result until the item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_r.accepted;
  assign out_present     = out_r.present;
  assign out_entry_valid = out_r.entry_valid;
  assign out_entry_task  = out_r.entry_task;
  assign out_entry_prio  = out_r.entry_prio;
  assign out_count       = out_r.count;

endmodule

`default_nettype wire

### verif/tb_priority_sorted_task_queue_unit.sv
`timescale 1ns / 100ps

module tb_priority_sorted_task_queue_unit;
  import pstq_pkg::*;

  localparam int QUEUE_DEPTH    = 32;
  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 100;
  localparam int CYCLE_LIMIT    = 900000;
  localparam int MAX_REPORTS    = 200;
  localparam logic [PrioW-1:0] PRIO_MAX = '1;

  // Action codes the block must ignore
  localparam logic [ActionW-1:0] ACT_RSVD_A = 3'd5;
  localparam logic [ActionW-1:0] ACT_RSVD_B = 3'd6;
  localparam logic [ActionW-1:0] ACT_RSVD_C = 3'd7;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [ActionW-1:0] in_action       = ACT_CLEAR;
  logic [TaskW-1:0]   in_task_id      = '0;
  logic [PrioW-1:0]   in_priority_req = '0;
  logic [PosW-1:0]    in_position     = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic               out_accepted;
  logic               out_present;
  logic               out_entry_valid;
  logic [TaskW-1:0]   out_entry_task;
  logic [PrioW-1:0]   out_entry_prio;
  logic [CountW-1:0]  out_count;

  // Shadow copy of the sorted list
  logic [TaskW-1:0] list_task [QUEUE_DEPTH];
  logic [PrioW-1:0] list_prio [QUEUE_DEPTH];
  int               list_len = 0;

  result_t pending_results[$];
  int      fail_count       = 0;
  int      results_checked  = 0;
  int      action_hits [8];
  int      full_rejects     = 0;
  int      cycle_count      = 0;
  int      stall_burst_left = 0;
  logic    calm_phase       = 1'b0;

  priority_sorted_task_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_task_id     (in_task_id),
    .in_priority_req(in_priority_req),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_accepted   (out_accepted),
    .out_present    (out_present),
    .out_entry_valid(out_entry_valid),
    .out_entry_task (out_entry_task),
    .out_entry_prio (out_entry_prio),
    .out_count      (out_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Apply one action to the shadow list and return the result it should give
  function automatic result_t apply_list_action(input logic [ActionW-1:0] act,
                                                input logic [TaskW-1:0] id,
                                                input logic [PrioW-1:0] prio,
                                                input logic [PosW-1:0] pos);
    result_t r;
    int      hit;
    int      slot;
    r   = '0;
    hit = list_len;
    for (int i = list_len - 1; i >= 0; i--)
      if (list_task[i] == id) hit = i;
    case (act)
      ACT_CLEAR: list_len = 0;
      ACT_ADD: begin
        if (list_len < QUEUE_DEPTH && hit == list_len) begin
          // insert behind every entry of equal or higher priority
          slot = 0;
          while (slot < list_len && list_prio[slot] >= prio) slot++;
          for (int k = list_len; k > slot; k--) begin
            list_task[k] = list_task[k - 1];
            list_prio[k] = list_prio[k - 1];
          end
          list_task[slot] = id;
          list_prio[slot] = prio;
          list_len++;
          r.accepted = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (hit < list_len) begin
          // close the gap
          for (int k = hit; k + 1 < list_len; k++) begin
            list_task[k] = list_task[k + 1];
            list_prio[k] = list_prio[k + 1];
          end
          list_len--;
          r.accepted = 1'b1;
        end
      end
      ACT_CONTAINS: r.present = (hit < list_len);
      ACT_READ: begin
        if (int'(pos) < list_len) begin
          r.entry_valid = 1'b1;
          r.entry_task  = list_task[pos];
          r.entry_prio  = list_prio[pos];
        end
      end
      default: ;
    endcase
    r.count = CountW'(list_len);
    return r;
  endfunction

  // Present one item, hold it until taken, then record its expected result
  task automatic send_list_action(input logic [ActionW-1:0] act,
                                  input logic [TaskW-1:0] id,
                                  input logic [PrioW-1:0] prio,
                                  input logic [PosW-1:0] pos);
    int gap;
    gap = 0;
    if (!calm_phase && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_task_id      <= id;
    in_priority_req <= prio;
    in_position     <= pos;
    do @(posedge clk); while (in_stall);
    if (act == ACT_ADD && list_len == QUEUE_DEPTH) full_rejects++;
    pending_results.push_back(apply_list_action(act, id, prio, pos));
    action_hits[act]++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic shuffle_ids(output logic [TaskW-1:0] ids [QUEUE_DEPTH]);
    int               pick;
    logic [TaskW-1:0] held;
    for (int i = 0; i < QUEUE_DEPTH; i++) ids[i] = TaskW'(i);
    for (int i = QUEUE_DEPTH - 1; i > 0; i--) begin
      pick      = $urandom_range(0, i);
      held      = ids[i];
      ids[i]    = ids[pick];
      ids[pick] = held;
    end
  endtask

  // Pick an action with content biased toward ids and positions that matter
  task automatic send_random_action(input int add_pct, input int prio_top);
    int               roll;
    logic [ActionW-1:0] act;
    logic [TaskW-1:0] id;
    logic [PosW-1:0]  pos;
    roll = $urandom_range(0, 99);
    if (roll < 2)                 act = ACT_CLEAR;
    else if (roll < 2 + add_pct)  act = ACT_ADD;
    else if (roll < 60)           act = ACT_REMOVE;
    else if (roll < 74)           act = ACT_CONTAINS;
    else if (roll < 97)           act = ACT_READ;
    else                          act = ActionW'(ACT_RSVD_A + $urandom_range(0, 2));
    if (list_len > 0 && act != ACT_ADD && $urandom_range(0, 9) < 6)
      id = list_task[$urandom_range(0, list_len - 1)];
    else
      id = TaskW'($urandom_range(0, QUEUE_DEPTH - 1));
    if ($urandom_range(0, 9) < 7)
      pos = PosW'($urandom_range(0, list_len));
    else
      pos = PosW'($urandom());
    send_list_action(act, id, PrioW'($urandom_range(0, prio_top)), pos);
  endtask

  task automatic test_directed_cases();
    // empty list corners
    send_list_action(ACT_CLEAR,    5'd0,  8'd0,   5'd0);
    send_list_action(ACT_READ,     5'd0,  8'd0,   5'd0);
    send_list_action(ACT_CONTAINS, 5'd31, 8'd0,   5'd0);
    send_list_action(ACT_REMOVE,   5'd7,  8'd0,   5'd0);
    // insert at both ends, equal priorities keep arrival order
    send_list_action(ACT_ADD,      5'd0,  8'd0,   5'd0);
    send_list_action(ACT_ADD,      5'd31, 8'd255, 5'd31);
    send_list_action(ACT_ADD,      5'd5,  8'd128, 5'd0);
    send_list_action(ACT_ADD,      5'd6,  8'd128, 5'd0);
    send_list_action(ACT_ADD,      5'd9,  8'd0,   5'd0);
    // duplicate id is rejected
    send_list_action(ACT_ADD,      5'd5,  8'd200, 5'd0);
    for (int p = 0; p < 5; p++)
      send_list_action(ACT_READ, 5'd0, 8'd0, PosW'(p));
    send_list_action(ACT_READ,     5'd31, 8'd255, 5'd31);
    send_list_action(ACT_CONTAINS, 5'd6,  8'd0,   5'd0);
    send_list_action(ACT_REMOVE,   5'd5,  8'd0,   5'd0);
    send_list_action(ACT_READ,     5'd0,  8'd0,   5'd1);
    // unused codes only report the count
    send_list_action(ACT_RSVD_A,   5'd31, 8'd255, 5'd31);
    send_list_action(ACT_RSVD_B,   5'd6,  8'd1,   5'd0);
    send_list_action(ACT_RSVD_C,   5'd0,  8'd0,   5'd2);
    send_list_action(ACT_REMOVE,   5'd31, 8'd0,   5'd0);
    send_list_action(ACT_CLEAR,    5'd31, 8'd255, 5'd31);
    send_list_action(ACT_READ,     5'd0,  8'd0,   5'd0);
  endtask

  // Fill every slot, bounce off the full list, read it all, then empty it
  task automatic test_fill_to_capacity(input int prio_top);
    logic [TaskW-1:0] ids [QUEUE_DEPTH];
    send_list_action(ACT_CLEAR, 5'd0, 8'd0, 5'd0);
    shuffle_ids(ids);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_list_action(ACT_ADD, ids[i], PrioW'($urandom_range(0, prio_top)), 5'd0);
    send_list_action(ACT_ADD, TaskW'($urandom()), PrioW'($urandom()), 5'd0);
    for (int p = 0; p < QUEUE_DEPTH; p++)
      send_list_action(ACT_READ, 5'd0, 8'd0, PosW'(p));
    send_list_action(ACT_CONTAINS, TaskW'($urandom()), 8'd0, 5'd0);
    shuffle_ids(ids);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_list_action(ACT_REMOVE, ids[i], 8'd0, 5'd0);
    send_list_action(ACT_REMOVE, ids[0], 8'd0, 5'd0);
    send_list_action(ACT_READ, 5'd0, 8'd0, 5'd0);
  endtask

  // Random traffic in chunks with varied add pressure and priority spread
  task automatic test_random_mix(input int total);
    int add_pct;
    int prio_top;
    add_pct  = 38;
    prio_top = PRIO_MAX;
    for (int n = 0; n < total; n++) begin
      if (n % 150 == 0) begin
        add_pct  = $urandom_range(20, 50);
        prio_top = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : PRIO_MAX;
      end
      if (n % 300 == 299) wait_results_drained();
      send_random_action(add_pct, prio_top);
    end
  endtask

  // Back-to-back items with the result side always ready
  task automatic test_back_to_back_stream(input int total);
    calm_phase <= 1'b1;
    for (int n = 0; n < total; n++)
      send_random_action(35, (n < total / 2) ? 3 : PRIO_MAX);
  endtask

  // Result side stalls in random bursts
  always @(posedge clk) begin
    if (!rst_n || calm_phase) begin
      stall_burst_left = 0;
      out_stall <= 1'b0;
    end else if (stall_burst_left > 0) begin
      stall_burst_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 11) == 0) stall_burst_left = $urandom_range(1, 19);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each taken result against the oldest expectation
  always @(posedge clk) begin : check_result
    result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual count %0d",
                   $time, out_count);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("accepted",    want.accepted,    out_accepted);
        check_field("present",     want.present,     out_present);
        check_field("entry_valid", want.entry_valid, out_entry_valid);
        check_field("entry_task",  want.entry_task,  out_entry_task);
        check_field("entry_prio",  want.entry_prio,  out_entry_prio);
        check_field("count",       want.count,       out_count);
      end
    end
  end

  initial begin
    foreach (action_hits[i]) action_hits[i] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    wait_results_drained();
    test_fill_to_capacity(PRIO_MAX);
    test_fill_to_capacity(2);
    wait_results_drained();
    test_random_mix(1150);
    test_back_to_back_stream(200);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;
    $display("Checked %0d results: %0d clear, %0d add, %0d remove, %0d contains, %0d read,",
             results_checked, action_hits[ACT_CLEAR], action_hits[ACT_ADD],
             action_hits[ACT_REMOVE], action_hits[ACT_CONTAINS], action_hits[ACT_READ]);
    $display("%0d unused codes, %0d adds against a full list, %0d failures",
             action_hits[ACT_RSVD_A] + action_hits[ACT_RSVD_B] + action_hits[ACT_RSVD_C],
             full_rejects, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
